FILE: rtl/core/fsc_pkg.sv
// fan speed and sweep controller: shared types, codes and reset values
package fsc_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned RangeW = 8;
  localparam int unsigned PulseW = 16;
  localparam int unsigned LedW   = 3;
  localparam int unsigned LevelW = 2;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_POWER = 2'd1,
    CMD_SPEED = 2'd2,
    CMD_OSC   = 2'd3
  } cmd_t;

  typedef enum logic [AddrW-1:0] {
    REG_DUTY_OFF    = 3'd0,
    REG_DUTY_LOW    = 3'd1,
    REG_DUTY_MEDIUM = 3'd2,
    REG_DUTY_HIGH   = 3'd3,
    REG_NEAR_LIMIT  = 3'd4,
    REG_SWEEP_UPPER = 3'd5,
    REG_SWEEP_LOWER = 3'd6
  } reg_idx_t;

  typedef logic [DutyW-1:0]  duty_t;
  typedef logic [PulseW-1:0] pulse_t;
  typedef logic [LedW-1:0]   leds_t;
  typedef logic [LevelW-1:0] level_t;

  localparam duty_t  DutyOffRst    = 8'd0;
  localparam duty_t  DutyLowRst    = 8'd100;
  localparam duty_t  DutyMediumRst = 8'd180;
  localparam duty_t  DutyHighRst   = 8'd255;
  localparam duty_t  NearLimitRst  = 8'd10;
  localparam pulse_t SweepUpperRst = 16'd4500;
  localparam pulse_t SweepLowerRst = 16'd1500;

  localparam level_t LevelLow    = 2'd0;
  localparam level_t LevelMedium = 2'd1;
  localparam level_t LevelHigh   = 2'd2;

  localparam leds_t LedsOff    = 3'b000;
  localparam leds_t LedsLow    = 3'b001;
  localparam leds_t LedsMedium = 3'b011;
  localparam leds_t LedsHigh   = 3'b111;

endpackage

FILE: rtl/core/fsc_if.sv
// fan speed and sweep controller: event, status and register write channels

interface fsc_in_if;
  logic                             valid;
  logic                             ready;
  logic [fsc_pkg::CmdW-1:0]         cmd;
  logic [fsc_pkg::RangeW-1:0]       range_sample;

  modport source (output valid, cmd, range_sample, input ready);
  modport sink   (input valid, cmd, range_sample, output ready);
endinterface

interface fsc_out_if;
  logic                             valid;
  logic                             ready;
  logic [fsc_pkg::DutyW-1:0]        fan_duty;
  logic [fsc_pkg::PulseW-1:0]       servo_pulse;
  logic [fsc_pkg::LedW-1:0]         level_leds;
  logic                             fan_running;
  logic [fsc_pkg::LevelW-1:0]       speed_level;
  logic                             sweeping;

  modport source (output valid, fan_duty, servo_pulse, level_leds, fan_running,
                  speed_level, sweeping, input ready);
  modport sink   (input valid, fan_duty, servo_pulse, level_leds, fan_running,
                  speed_level, sweeping, output ready);
endinterface

interface fsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fsc_pkg::AddrW-1:0]        addr;
  logic [fsc_pkg::DataW-1:0]        data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/fan_speed_and_sweep_controller.sv
// fan speed and sweep controller: top level, event decode and state update
// latency: a status word is registered and appears in the cycle after its event word is accepted
// throughput: one event word per cycle; the single status register frees
//   itself in the same cycle it is taken, so ready only drops on a stall
// reset (rst_n low, synchronous): fan off, level low, sweep off, pulse and
//   duty zero, sample phase zero, registers back to their default values
module fan_speed_and_sweep_controller #(
  parameter int unsigned SAMPLE_TICKS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  fsc_in_if.sink    in_ch,
  fsc_out_if.source out_ch,
  fsc_cfg_if.sink   cfg_ch
);

  localparam int unsigned PhaseW = $clog2(SAMPLE_TICKS);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(SAMPLE_TICKS - 1);

  // configuration registers
  fsc_pkg::duty_t  duty_off_r, duty_low_r, duty_medium_r, duty_high_r, near_limit_r;
  fsc_pkg::pulse_t sweep_upper_r, sweep_lower_r;

  // controller state; all but the phase and sweep direction registers are also the status word shown on out_ch
  logic             running_r,    running_nxt;
  fsc_pkg::level_t  level_r,      level_nxt;
  logic             sweep_en_r,   sweep_en_nxt;
  logic             sweep_down_r, sweep_down_nxt;
  logic [PhaseW-1:0] phase_r,     phase_nxt;
  fsc_pkg::duty_t   duty_r,       duty_nxt;
  fsc_pkg::pulse_t  pulse_r,      pulse_nxt;
  fsc_pkg::leds_t   leds_r,       leds_nxt;
  logic             out_valid_r,  out_valid_nxt;

  logic            in_fire;
  fsc_pkg::cmd_t   cmd;
  fsc_pkg::level_t level_step;
  fsc_pkg::duty_t  step_duty;   // duty of the level after a speed press
  fsc_pkg::duty_t  cur_duty;    // duty of the current level on a sample tick
  fsc_pkg::leds_t  step_leds;
  fsc_pkg::pulse_t pulse_up, pulse_dn;

  // the status register is free when empty or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd         = fsc_pkg::cmd_t'(in_ch.cmd);

  // register writes never stall
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_off_r    <= fsc_pkg::DutyOffRst;
      duty_low_r    <= fsc_pkg::DutyLowRst;
      duty_medium_r <= fsc_pkg::DutyMediumRst;
      duty_high_r   <= fsc_pkg::DutyHighRst;
      near_limit_r  <= fsc_pkg::NearLimitRst;
      sweep_upper_r <= fsc_pkg::SweepUpperRst;
      sweep_lower_r <= fsc_pkg::SweepLowerRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        fsc_pkg::REG_DUTY_OFF:    duty_off_r    <= cfg_ch.data[fsc_pkg::DutyW-1:0];
        fsc_pkg::REG_DUTY_LOW:    duty_low_r    <= cfg_ch.data[fsc_pkg::DutyW-1:0];
        fsc_pkg::REG_DUTY_MEDIUM: duty_medium_r <= cfg_ch.data[fsc_pkg::DutyW-1:0];
        fsc_pkg::REG_DUTY_HIGH:   duty_high_r   <= cfg_ch.data[fsc_pkg::DutyW-1:0];
        fsc_pkg::REG_NEAR_LIMIT:  near_limit_r  <= cfg_ch.data[fsc_pkg::DutyW-1:0];
        fsc_pkg::REG_SWEEP_UPPER: sweep_upper_r <= cfg_ch.data;
        fsc_pkg::REG_SWEEP_LOWER: sweep_lower_r <= cfg_ch.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // level stepping, modulo three
  always_comb begin
    level_step = (level_r == fsc_pkg::LevelHigh) ? fsc_pkg::LevelLow : level_r + 2'd1;

    case (level_step)
      fsc_pkg::LevelLow: begin
        step_duty = duty_low_r;
        step_leds = fsc_pkg::LedsLow;
      end
      fsc_pkg::LevelMedium: begin
        step_duty = duty_medium_r;
        step_leds = fsc_pkg::LedsMedium;
      end
      fsc_pkg::LevelHigh: begin
        step_duty = duty_high_r;
        step_leds = fsc_pkg::LedsHigh;
      end
      default: begin
        step_duty = duty_r;
        step_leds = leds_r;
      end
    endcase

    // level code three cannot occur; it keeps the present duty
    case (level_r)
      fsc_pkg::LevelLow:    cur_duty = duty_low_r;
      fsc_pkg::LevelMedium: cur_duty = duty_medium_r;
      fsc_pkg::LevelHigh:   cur_duty = duty_high_r;
      default:              cur_duty = duty_r;
    endcase

    // servo pulse wraps modulo 2^16 in both directions
    pulse_up = pulse_r + 16'd1;
    pulse_dn = pulse_r - 16'd1;
  end

  // next state for one accepted event word
  always_comb begin
    running_nxt    = running_r;
    level_nxt      = level_r;
    sweep_en_nxt   = sweep_en_r;
    sweep_down_nxt = sweep_down_r;
    phase_nxt      = phase_r;
    duty_nxt       = duty_r;
    pulse_nxt      = pulse_r;
    leds_nxt       = leds_r;

    case (cmd)
      fsc_pkg::CMD_TICK: begin
        if (!running_r) begin
          sweep_en_nxt = 1'b0;
        end else if (sweep_en_r) begin
          // bounce: each bound is checked after the one-count move
          if (!sweep_down_r) begin
            pulse_nxt = pulse_up;
            if (pulse_up > sweep_upper_r) sweep_down_nxt = 1'b1;
          end else begin
            pulse_nxt = pulse_dn;
            if (pulse_dn < sweep_lower_r) sweep_down_nxt = 1'b0;
          end
        end
        // distance is looked at only on the last tick of each sample period
        if (phase_r != PhaseLast) begin
          phase_nxt = phase_r + PhaseW'(1);
        end else begin
          phase_nxt = '0;
          if (running_r) begin
            duty_nxt = (in_ch.range_sample < near_limit_r) ? duty_off_r : cur_duty;
          end
        end
      end
      fsc_pkg::CMD_POWER: begin
        running_nxt = !running_r;
        if (!running_r) begin
          // switching on always starts at the low duty, level is kept
          duty_nxt = duty_low_r;
          leds_nxt = fsc_pkg::LedsLow;
        end else begin
          duty_nxt     = duty_off_r;
          leds_nxt     = fsc_pkg::LedsOff;
          sweep_en_nxt = 1'b0;
        end
      end
      fsc_pkg::CMD_SPEED: begin
        // level steps even while off; duty and leds follow only while running
        level_nxt = level_step;
        if (running_r) begin
          duty_nxt = step_duty;
          leds_nxt = step_leds;
        end
      end
      fsc_pkg::CMD_OSC: begin
        if (running_r) sweep_en_nxt = !sweep_en_r;
      end
      default: ;
    endcase
  end

  // status word valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      level_r      <= fsc_pkg::LevelLow;
      sweep_en_r   <= 1'b0;
      sweep_down_r <= 1'b0;
      phase_r      <= '0;
      duty_r       <= '0;
      pulse_r      <= '0;
      leds_r       <= fsc_pkg::LedsOff;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        running_r    <= running_nxt;
        level_r      <= level_nxt;
        sweep_en_r   <= sweep_en_nxt;
        sweep_down_r <= sweep_down_nxt;
        phase_r      <= phase_nxt;
        duty_r       <= duty_nxt;
        pulse_r      <= pulse_nxt;
        leds_r       <= leds_nxt;
      end
    end
  end

  // the state only moves when a new word is accepted, which also refills the
  // status slot, so the state registers double as the held status word
  assign out_ch.valid       = out_valid_r;
  assign out_ch.fan_duty    = duty_r;
  assign out_ch.servo_pulse = pulse_r;
  assign out_ch.level_leds  = leds_r;
  assign out_ch.fan_running = running_r;
  assign out_ch.speed_level = level_r;
  assign out_ch.sweeping    = sweep_en_r;

endmodule
